### src/pss_pkg.sv
// Shared types and constants for the price stream statistics block.
`default_nettype none
package pss_pkg;
  localparam int PRICE_W = 23;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 63;
  localparam int ACC_W   = 80;
  localparam int ROOT_W  = 40;
  localparam int DVD_W   = 40;
  localparam int DRM_W   = 24;
  localparam int SRM_W   = 44;
  localparam int CHG_W   = 32;
  localparam int STEP_W  = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;
  localparam logic [13:0] PCT_SCALE = 14'd10000;

  localparam logic [STEP_W-1:0] MULA_LAST = 6'd17;
  localparam logic [STEP_W-1:0] MULB_LAST = 6'd40;
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd40;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd41;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULA, ST_MULB, ST_SQRT, ST_DIVM, ST_DIVC, ST_DIVD, ST_PUB
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_MULA_LOAD, OP_MULB_LOAD, OP_MUL_STEP,
    OP_SQRT_LOAD, OP_SQRT_STEP, OP_DIVM_LOAD, OP_DIVC_LOAD, OP_DIVD_LOAD,
    OP_DIV_STEP, OP_STORE_MEAN, OP_STORE_CHG, OP_STORE_DEV, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

### src/pss_ctrl.sv
// Controller state machine sequencing the shared multiply, root and divide steps.
`default_nettype none
module pss_ctrl import pss_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd.op = (cnt_r == '0) ? OP_MULA_LOAD : OP_MUL_STEP;
        if (cnt_r == MULA_LAST) begin
          state_nxt = ST_MULB;
          cnt_nxt   = '0;
        end
      end
      ST_MULB: begin
        cmd.op = (cnt_r == '0) ? OP_MULB_LOAD : OP_MUL_STEP;
        if (cnt_r == MULB_LAST) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end
      end
      ST_SQRT: begin
        cmd.op = (cnt_r == '0) ? OP_SQRT_LOAD : OP_SQRT_STEP;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_DIVM;
          cnt_nxt   = '0;
        end
      end
      ST_DIVM: begin
        cmd.op = (cnt_r == '0) ? OP_DIVM_LOAD :
                 (cnt_r == DIV_LAST) ? OP_STORE_MEAN : OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DIVC;
          cnt_nxt   = '0;
        end
      end
      ST_DIVC: begin
        cmd.op = (cnt_r == '0) ? OP_DIVC_LOAD :
                 (cnt_r == DIV_LAST) ? OP_STORE_CHG : OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DIVD;
          cnt_nxt   = '0;
        end
      end
      ST_DIVD: begin
        cmd.op = (cnt_r == '0) ? OP_DIVD_LOAD :
                 (cnt_r == DIV_LAST) ? OP_STORE_DEV : OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_PUB;
          cnt_nxt   = '0;
        end
      end
      ST_PUB: begin
        cnt_nxt = '0;
        if (stat.out_free) begin
          cmd.op    = OP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end
endmodule
`default_nettype wire

### src/pss_datapath.sv
// Datapath with history registers, serial multiplier, square root and divider.
`default_nettype none
module pss_datapath import pss_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  parameter int PRICE_BITS  = 23
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  wire logic [PRICE_W-1:0]    price,
  input  wire logic                  restart,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CNT_W-1:0]           o_total,
  output logic [PRICE_W-1:0]         o_mean,
  output logic [CHG_W-1:0]           o_change,
  output logic [PRICE_W-1:0]         o_dev,
  output logic                       o_zerr,
  output logic                       o_drop
);
  localparam logic [PRICE_W-1:0] PMASK = PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0]   CMAX  = CNT_W'(MAX_SAMPLES);

  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]    sumsq_r;
  logic [PRICE_W-1:0] first_r, latest_r;
  logic               drop_r;
  logic [ACC_W-1:0]   mcand_r, acc_r;
  logic [SUM_W-1:0]   mplier_r;
  logic               sub_r;
  logic [SRM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [PRICE_W-1:0] dvs_r;
  logic [DRM_W-1:0]   drem_r;
  logic               neg_r;
  logic [PRICE_W-1:0] mean_r, dev_r;
  logic [CHG_W-1:0]   chg_r;
  logic               valid_r;

  logic [PRICE_W-1:0]   p;
  logic [2*PRICE_W-1:0] psq;
  logic [PRICE_W:0]     diff, mag;
  logic [SRM_W-1:0]     s_pre, s_trial;
  logic [DRM_W-1:0]     d_pre;
  logic                 many, zerr;

  assign p     = price & PMASK;
  assign psq   = p * p;
  assign diff  = {1'b0, latest_r} - {1'b0, first_r};
  assign mag   = diff[PRICE_W] ? (~diff + 1'b1) : diff;
  assign s_pre   = {srem_r[SRM_W-3:0], acc_r[ACC_W-1 -: 2]};
  assign s_trial = SRM_W'({root_r, 2'b01});
  assign d_pre   = {drem_r[DRM_W-2:0], dvd_r[DVD_W-1]};
  assign many  = (count_r >= CNT_W'(2));
  assign zerr  = many && (first_r == '0);
  assign stat.out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      sumsq_r  <= '0;
      first_r  <= '0;
      latest_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_PUBLISH) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      case (cmd.op)
        OP_CAPTURE: begin
          drop_r <= 1'b0;
          if (restart || count_r == '0) begin
            count_r  <= CNT_W'(1);
            sum_r    <= SUM_W'(p);
            sumsq_r  <= SQ_W'(psq);
            first_r  <= p;
            latest_r <= p;
          end else if (count_r >= CMAX) begin
            drop_r <= 1'b1;
          end else begin
            count_r  <= count_r + 1'b1;
            sum_r    <= sum_r + SUM_W'(p);
            sumsq_r  <= sumsq_r + SQ_W'(psq);
            latest_r <= p;
          end
        end
        OP_MULA_LOAD: begin
          mcand_r  <= ACC_W'(sumsq_r);
          mplier_r <= SUM_W'(count_r);
          acc_r    <= '0;
          sub_r    <= 1'b0;
        end
        OP_MULB_LOAD: begin
          mcand_r  <= ACC_W'(sum_r);
          mplier_r <= sum_r;
          sub_r    <= 1'b1;
        end
        OP_MUL_STEP: begin
          if (mplier_r[0]) acc_r <= sub_r ? acc_r - mcand_r : acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
        OP_SQRT_LOAD: begin
          srem_r <= '0;
          root_r <= '0;
        end
        OP_SQRT_STEP: begin
          acc_r <= acc_r << 2;
          if (s_pre >= s_trial) begin
            srem_r <= s_pre - s_trial;
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            srem_r <= s_pre;
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
        end
        OP_DIVM_LOAD: begin
          dvd_r  <= sum_r;
          dvs_r  <= PRICE_W'(count_r);
          drem_r <= '0;
        end
        OP_DIVC_LOAD: begin
          dvd_r  <= DVD_W'(mag) * DVD_W'(PCT_SCALE);
          dvs_r  <= first_r;
          neg_r  <= diff[PRICE_W];
          drem_r <= '0;
        end
        OP_DIVD_LOAD: begin
          dvd_r  <= root_r;
          dvs_r  <= PRICE_W'(count_r);
          drem_r <= '0;
        end
        OP_DIV_STEP: begin
          if (d_pre >= {1'b0, dvs_r}) begin
            drem_r <= d_pre - {1'b0, dvs_r};
            dvd_r  <= {dvd_r[DVD_W-2:0], 1'b1};
          end else begin
            drem_r <= d_pre;
            dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
          end
        end
        OP_STORE_MEAN: mean_r <= dvd_r[PRICE_W-1:0];
        OP_STORE_CHG: begin
          if (!many || zerr) chg_r <= '0;
          else if (neg_r) chg_r <= ~dvd_r[CHG_W-1:0] + 1'b1;
          else if (dvd_r > DVD_W'(32'h7FFF_FFFF)) chg_r <= 32'h7FFF_FFFF;
          else chg_r <= dvd_r[CHG_W-1:0];
        end
        OP_STORE_DEV: dev_r <= many ? dvd_r[PRICE_W-1:0] : '0;
        OP_PUBLISH: begin
          o_total  <= count_r;
          o_mean   <= mean_r;
          o_change <= chg_r;
          o_dev    <= dev_r;
          o_zerr   <= zerr;
          o_drop   <= drop_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = valid_r;
endmodule
`default_nettype wire

### src/price_stream_statistics.sv
// Top level of the price stream statistics block.
//   Channel  Direction  tdata (low bit up)                       tuser
//   in_      input      price[22:0], pad                         restart
//   out_     output     total, mean, change, deviation, pad      zero_first_error, full_dropped
// A transaction runs through the shared serial datapath:
// a 17-step shift-add and a 40-step shift-subtract multiply, a 40-step square
// root and three 40-step divides, each one bit a cycle, plus their load and store cycles.
// Reset clears the history and the output valid flag.
// A new input transaction is taken while a finished result still waits.
`default_nettype none
module price_stream_statistics import pss_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  parameter int PRICE_BITS  = 23
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // price[22:0], zero pad
  input  wire logic                  in_tuser,   // restart
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // total, mean, change, deviation, pad
  output logic [1:0]                 out_tuser   // zero_first_error, full_dropped
);
  cmd_t  cmd;
  stat_t stat;
  logic [CNT_W-1:0]   o_total;
  logic [PRICE_W-1:0] o_mean, o_dev;
  logic [CHG_W-1:0]   o_change;
  logic               o_zerr, o_drop;

  pss_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .stat, .cmd
  );

  pss_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .PRICE_BITS(PRICE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .price(in_tdata[PRICE_W-1:0]), .restart(in_tuser),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_total, .o_mean, .o_change, .o_dev, .o_zerr, .o_drop
  );

  assign out_tdata = {1'b0, o_dev, o_change, o_mean, o_total};
  assign out_tuser = {o_drop, o_zerr};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PUBLISH |-> (!out_tvalid || out_tready)) else $error("result overwritten");
  a_zerr_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[71:40] == 32'd0) else $error("change with zero first");
  a_few_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16:0] < 17'd2 |->
      out_tdata[94:72] == 23'd0 && out_tdata[71:40] == 32'd0)
    else $error("statistics below two samples");
endmodule
`default_nettype wire
